// File: sv/assert_macros.svh
// Assertion helpers used by the temperature unit RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge while reset is released.
`define ATEMP_ASSERT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every rising edge, reset included.
`define ATEMP_ASSERT_ALWAYS(name, clk, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: sv/atemp_pkg.sv
`default_nettype none

package atemp_pkg;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_CODE_ZERO = 2'd1,
        ST_CODE_FULL = 2'd2,
        ST_SAT       = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        CFG_BETA     = 2'd0,
        CFG_REF_RES  = 2'd1,
        CFG_REF_TEMP = 2'd2,
        CFG_SERIES   = 2'd3
    } t_cfg_idx;

    localparam int CFG_DATA_W = 24;

    localparam logic [17:0] BETA_RST     = 18'd57256;
    localparam logic [23:0] REF_RES_RST  = 24'd19632;
    localparam logic [15:0] REF_TEMP_RST = 16'd18762;
    localparam logic [19:0] SERIES_RST   = 20'd1000;

    // Log2 mantissa is held in Q30 with the leading one at bit 30.
    localparam int MANT_W    = 31;
    localparam int MANT_FRAC = 30;
    localparam int LOG_FRAC  = 24;
    localparam int LOG_LAT   = LOG_FRAC + 2;

    localparam logic [29:0] LN2_Q30 = 30'd744261118;

    // Quotient range that saturates both outputs for every supported fraction width.
    localparam int QUO_BITS = 20;

    typedef struct packed {
        logic zero;
        logic full;
        logic bad;
        logic nz;
        logic inf;
        logic ovf;
    } t_tag;

    typedef struct packed {
        logic [15:0]        kel;
        logic signed [15:0] cel;
        t_status            st;
    } t_result;

endpackage

`default_nettype wire

// File: sv/atemp_if.sv
`default_nettype none

interface atemp_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] adc_code;
    modport source (output valid, output adc_code, input ready);
    modport sink (input valid, input adc_code, output ready);
endinterface

interface atemp_out_if;
    logic               valid;
    logic               ready;
    logic [15:0]        kelvin_val;
    logic signed [15:0] celsius_val;
    atemp_pkg::t_status status;
    modport source (output valid, output kelvin_val, output celsius_val, output status,
                    input ready);
    modport sink (input valid, input kelvin_val, input celsius_val, input status,
                  output ready);
endinterface

interface atemp_cfg_if;
    logic                              valid;
    logic                              ready;
    atemp_pkg::t_cfg_idx               index;
    logic [atemp_pkg::CFG_DATA_W-1:0]  data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: sv/adc_thermistor_temperature_unit.sv
// Converts one ADC sample of an NTC thermistor divider per clock into temperature in kelvin
// and Celsius with TEMP_FRAC_BITS fractional bits, using the beta equation. Results pass
// through one input stage, 26 stages per log2 unit, six stages of log scaling and
// denominator forming, 21 divider stages and one result stage. A new sample is taken every
// cycle; a one-entry skid register behind the result stage takes a result the sink does
// not accept, and input ready drops only while that register is full. Configuration writes
// are always ready and must be issued only while no sample is in flight. status reports a
// zero code, a full-scale code, or saturation.
`default_nettype none

`include "assert_macros.svh"

module adc_thermistor_temperature_unit #(
    parameter int ADC_BITS       = 16,
    parameter int TEMP_FRAC_BITS = 6
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    atemp_in_if.sink     i_in,
    atemp_cfg_if.sink    i_cfg,
    atemp_out_if.source  o_out
);

    localparam int X_W     = ADC_BITS + 24;
    localparam int NB      = $clog2(X_W);
    localparam int LW      = NB + atemp_pkg::LOG_FRAC;
    localparam int PROD_W  = LW + 30;
    localparam int DQ_W    = LW + 18;
    localparam int DV_W    = DQ_W - 1;
    localparam int NQ_W    = 34;
    localparam int Q2_W    = atemp_pkg::QUO_BITS + 1;
    localparam int LOG_LAT = atemp_pkg::LOG_LAT;
    localparam int C273    = (27315 * (2 ** TEMP_FRAC_BITS) + 50) / 100;

    logic [17:0] r_beta;
    logic [23:0] r_ref_res;
    logic [15:0] r_ref_temp;
    logic [19:0] r_series;

    logic en;

    // Configuration registers.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_beta     <= atemp_pkg::BETA_RST;
            r_ref_res  <= atemp_pkg::REF_RES_RST;
            r_ref_temp <= atemp_pkg::REF_TEMP_RST;
            r_series   <= atemp_pkg::SERIES_RST;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                atemp_pkg::CFG_BETA:     r_beta     <= i_cfg.data[17:0];
                atemp_pkg::CFG_REF_RES:  r_ref_res  <= i_cfg.data[23:0];
                atemp_pkg::CFG_REF_TEMP: r_ref_temp <= i_cfg.data[15:0];
                atemp_pkg::CFG_SERIES:   r_series   <= i_cfg.data[19:0];
                default: ;
            endcase
        end
    end

    // Input stage: divider ratio operands.
    logic [ADC_BITS-1:0] code;
    logic [ADC_BITS-1:0] full_scale;
    logic [X_W-1:0]      n1_num;
    logic [X_W-1:0]      n1_den;
    logic                r1_v;
    atemp_pkg::t_tag     r1_tag;
    logic [X_W-1:0]      r1_num;
    logic [X_W-1:0]      r1_den;

    assign i_in.ready = en;
    assign code       = ADC_BITS'(i_in.adc_code);
    assign full_scale = {ADC_BITS{1'b1}};
    assign n1_num     = (X_W'(r_series) * X_W'(code)) << 4;
    assign n1_den     = X_W'(r_ref_res) * X_W'(full_scale - code);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (en) begin
            r1_v <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_num      <= n1_num;
            r1_den      <= n1_den;
            r1_tag.zero <= code == '0;
            r1_tag.full <= code == full_scale;
            r1_tag.bad  <= (r_series == '0) || (r_ref_res == '0);
            r1_tag.nz   <= 1'b0;
            r1_tag.inf  <= 1'b0;
            r1_tag.ovf  <= 1'b0;
        end
    end

    // Two log2 units run side by side.
    logic [LW-1:0]   log_num;
    logic [LW-1:0]   log_den;
    logic            r_lv   [LOG_LAT];
    atemp_pkg::t_tag r_ltag [LOG_LAT];

    atemp_log2 #(.X_W(X_W)) u_log_num (
        .i_clk (i_clk),
        .i_en  (en),
        .i_x   (r1_num),
        .o_log (log_num)
    );

    atemp_log2 #(.X_W(X_W)) u_log_den (
        .i_clk (i_clk),
        .i_en  (en),
        .i_x   (r1_den),
        .o_log (log_den)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < LOG_LAT; k++) begin
                r_lv[k] <= 1'b0;
            end
        end else if (en) begin
            r_lv[0] <= r1_v;
            for (int k = 1; k < LOG_LAT; k++) begin
                r_lv[k] <= r_lv[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ltag[0] <= r1_tag;
            for (int k = 1; k < LOG_LAT; k++) begin
                r_ltag[k] <= r_ltag[k-1];
            end
        end
    end

    // Log difference, ln scaling, denominator and numerator.
    logic signed [LW:0]     diff;
    logic [LW:0]            diff_abs;
    logic [PROD_W-1:0]      rnd_sum;
    logic [LW-1:0]          ln_mag;
    logic signed [DQ_W-1:0] beta_q30;
    logic signed [DQ_W-1:0] n6_dq;
    atemp_pkg::t_tag        n6_tag, n7_tag;

    logic                   r2_v, r3_v, r4_v, r5_v, r6_v, r7_v;
    atemp_pkg::t_tag        r2_tag, r3_tag, r4_tag, r5_tag, r6_tag, r7_tag;
    logic                   r2_neg, r3_neg;
    logic [LW-1:0]          r2_mag;
    logic [PROD_W-1:0]      r3_prod;
    logic signed [LW:0]     r4_lnq;
    logic signed [DQ_W-1:0] r5_p;
    logic [NQ_W-1:0]        r5_nq;
    logic [DV_W-1:0]        r6_ud, r7_ud;
    logic [DV_W-1:0]        r6_rem0, r7_rem0;

    assign diff     = $signed({1'b0, log_num}) - $signed({1'b0, log_den});
    assign diff_abs = diff[LW] ? (LW+1)'(-diff) : diff;
    assign rnd_sum  = r3_prod + PROD_W'(1 << 29);
    assign ln_mag   = rnd_sum[PROD_W-1:30];
    assign beta_q30 = $signed(DQ_W'({r_beta, 26'b0}));
    assign n6_dq    = r5_p + beta_q30;

    always_comb begin
        n6_tag     = r5_tag;
        n6_tag.nz  = r5_nq == '0;
        n6_tag.inf = n6_dq[DQ_W-1] || (n6_dq == '0);
        // A quotient at or above 2^QUO_BITS saturates both outputs.
        n7_tag     = r6_tag;
        n7_tag.ovf = r6_rem0 >= r6_ud;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
            r5_v <= 1'b0;
            r6_v <= 1'b0;
            r7_v <= 1'b0;
        end else if (en) begin
            r2_v <= r_lv[LOG_LAT-1];
            r3_v <= r2_v;
            r4_v <= r3_v;
            r5_v <= r4_v;
            r6_v <= r5_v;
            r7_v <= r6_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_tag  <= r_ltag[LOG_LAT-1];
            r2_neg  <= diff[LW];
            r2_mag  <= diff_abs[LW-1:0];

            r3_tag  <= r2_tag;
            r3_neg  <= r2_neg;
            r3_prod <= PROD_W'(r2_mag) * PROD_W'(atemp_pkg::LN2_Q30);

            r4_tag  <= r3_tag;
            r4_lnq  <= r3_neg ? -$signed({1'b0, ln_mag}) : $signed({1'b0, ln_mag});

            r5_tag  <= r4_tag;
            r5_p    <= DQ_W'(r4_lnq) * $signed(DQ_W'(r_ref_temp));
            r5_nq   <= NQ_W'(r_beta) * NQ_W'(r_ref_temp);

            r6_tag  <= n6_tag;
            r6_ud   <= n6_dq[DV_W-1:0];
            r6_rem0 <= DV_W'(r5_nq) << TEMP_FRAC_BITS;

            r7_tag  <= n7_tag;
            r7_ud   <= r6_ud;
            r7_rem0 <= r6_rem0;
        end
    end

    // Divider: doubled quotient for round-half-up.
    logic [Q2_W-1:0] q2;
    logic            r_dv   [Q2_W];
    atemp_pkg::t_tag r_dtag [Q2_W];

    atemp_div #(.DV_W(DV_W), .Q_W(Q2_W)) u_div (
        .i_clk (i_clk),
        .i_en  (en),
        .i_rem (r7_rem0),
        .i_div (r7_ud),
        .o_quo (q2)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < Q2_W; k++) begin
                r_dv[k] <= 1'b0;
            end
        end else if (en) begin
            r_dv[0] <= r7_v;
            for (int k = 1; k < Q2_W; k++) begin
                r_dv[k] <= r_dv[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dtag[0] <= r7_tag;
            for (int k = 1; k < Q2_W; k++) begin
                r_dtag[k] <= r_dtag[k-1];
            end
        end
    end

    // Result stage: rounding, Celsius offset, saturation, status.
    atemp_pkg::t_tag    ft;
    logic [Q2_W:0]      q2_inc;
    logic [Q2_W-1:0]    tq;
    logic               big;
    logic signed [23:0] cel_w;
    logic               kel_sat;
    logic               cel_sat;
    atemp_pkg::t_result n_out;
    atemp_pkg::t_result r_out;
    atemp_pkg::t_result r_skid;
    logic               r_out_v;
    logic               r_skid_full;

    assign ft     = r_dtag[Q2_W-1];
    assign q2_inc = {1'b0, q2} + (Q2_W+1)'(1);
    assign tq     = (ft.nz || ft.bad) ? '0 : q2_inc[Q2_W:1];
    assign big    = !(ft.nz || ft.bad) && (ft.inf || ft.ovf);
    assign cel_w  = $signed(24'(tq)) - $signed(24'(C273));

    always_comb begin
        n_out   = '0;
        kel_sat = 1'b0;
        cel_sat = 1'b0;
        if (big) begin
            n_out.kel = 16'hFFFF;
            n_out.cel = 16'sh7FFF;
            kel_sat   = 1'b1;
        end else begin
            if (tq[Q2_W-1:16] != '0) begin
                n_out.kel = 16'hFFFF;
                kel_sat   = 1'b1;
            end else begin
                n_out.kel = tq[15:0];
            end
            if (cel_w > 24'sd32767) begin
                n_out.cel = 16'sh7FFF;
                cel_sat   = 1'b1;
            end else if (cel_w < -24'sd32768) begin
                n_out.cel = 16'sh8000;
                cel_sat   = 1'b1;
            end else begin
                n_out.cel = cel_w[15:0];
            end
        end
        priority if (ft.zero) begin
            n_out.kel = '0;
            n_out.cel = '0;
            n_out.st  = atemp_pkg::ST_CODE_ZERO;
        end else if (ft.full) begin
            n_out.kel = '0;
            n_out.cel = '0;
            n_out.st  = atemp_pkg::ST_CODE_FULL;
        end else if (ft.bad || big || kel_sat || cel_sat) begin
            n_out.st  = atemp_pkg::ST_SAT;
        end else begin
            n_out.st  = atemp_pkg::ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (en) begin
            r_out_v <= r_dv[Q2_W-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out <= n_out;
        end
    end

    // Skid register: catches the result stage when the sink stalls, so the
    // pipeline advances in that cycle and freezes only while it is full.
    assign en = !r_skid_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skid_full <= 1'b0;
        end else if (r_skid_full) begin
            if (o_out.ready) begin
                r_skid_full <= 1'b0;
            end
        end else if (r_out_v && !o_out.ready) begin
            r_skid_full <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_skid_full) begin
            r_skid <= r_out;
        end
    end

    assign o_out.valid       = r_skid_full || r_out_v;
    assign o_out.kelvin_val  = r_skid_full ? r_skid.kel : r_out.kel;
    assign o_out.celsius_val = r_skid_full ? r_skid.cel : r_out.cel;
    assign o_out.status      = r_skid_full ? r_skid.st : r_out.st;

    logic signed [23:0] chk_cel_from_kel;
    logic signed [23:0] chk_cel;
    logic               chk_zero_ok;

    assign chk_cel_from_kel = $signed(24'(o_out.kelvin_val)) - $signed(24'(C273));
    assign chk_cel          = 24'(o_out.celsius_val);
    assign chk_zero_ok      = (o_out.kelvin_val == '0) && (o_out.celsius_val == '0);

    `ATEMP_ASSERT(a_ok_consistent, i_clk, i_rst_n, (o_out.valid && o_out.status == atemp_pkg::ST_OK) |-> (chk_cel_from_kel == chk_cel), "unsaturated Celsius does not match kelvin")
    `ATEMP_ASSERT(a_code_zero, i_clk, i_rst_n, (o_out.valid && (o_out.status == atemp_pkg::ST_CODE_ZERO || o_out.status == atemp_pkg::ST_CODE_FULL)) |-> chk_zero_ok, "flagged code gives nonzero temperature")
    `ATEMP_ASSERT(a_skid_holds, i_clk, i_rst_n, (r_skid_full && !o_out.ready) |=> r_skid_full, "skid entry dropped while stalled")
    `ATEMP_ASSERT(a_frozen, i_clk, i_rst_n, r_skid_full |=> $stable(r_out_v) && $stable(r_out), "result stage moved while skid full")

endmodule

`default_nettype wire

// File: sv/atemp_log2.sv
`default_nettype none

module atemp_log2 #(
    parameter int X_W = 40
) (
    input  logic                                          i_clk,
    input  logic                                          i_en,
    input  logic [X_W-1:0]                                i_x,
    output logic [$clog2(X_W)+atemp_pkg::LOG_FRAC-1:0]    o_log
);

    localparam int NB = $clog2(X_W);
    localparam int MW = atemp_pkg::MANT_W;
    localparam int FW = atemp_pkg::LOG_FRAC;
    localparam int MF = atemp_pkg::MANT_FRAC;

    logic [X_W-1:0] r_x0;
    logic [NB-1:0]  r_n0;
    logic [NB-1:0]  n_n0;
    logic [MW-1:0]  r_m1;
    logic [NB-1:0]  r_n1;
    logic [X_W-1:0] shifted;

    logic [MW-1:0]  r_sm [FW];
    logic [FW-1:0]  r_sf [FW];
    logic [NB-1:0]  r_sn [FW];

    always_comb begin
        n_n0 = '0;
        for (int i = 0; i < X_W; i++) begin
            if (i_x[i]) begin
                n_n0 = NB'(i);
            end
        end
    end

    // Move the leading one to the top; bits below Q30 fall off.
    assign shifted = r_x0 << (NB'(X_W - 1) - r_n0);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x0 <= i_x;
            r_n0 <= n_n0;
            r_m1 <= shifted[X_W-1 -: MW];
            r_n1 <= r_n0;
        end
    end

    genvar k;
    for (k = 0; k < FW; k++) begin : g_sq
        logic [MW-1:0]   src_m;
        logic [FW-1:0]   src_f;
        logic [NB-1:0]   src_n;
        logic [2*MW-1:0] sq;
        logic [MW:0]     top;
        if (k == 0) begin : g_first
            assign src_m = r_m1;
            assign src_f = '0;
            assign src_n = r_n1;
        end else begin : g_next
            assign src_m = r_sm[k-1];
            assign src_f = r_sf[k-1];
            assign src_n = r_sn[k-1];
        end
        assign sq  = (2*MW)'(src_m) * (2*MW)'(src_m);
        assign top = sq[2*MW-1:MF];
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_sm[k] <= top[MW] ? top[MW:1] : top[MW-1:0];
                r_sf[k] <= {src_f[FW-2:0], top[MW]};
                r_sn[k] <= src_n;
            end
        end
    end

    assign o_log = {r_sn[FW-1], r_sf[FW-1]};

endmodule

`default_nettype wire

// File: sv/atemp_div.sv
`default_nettype none

module atemp_div #(
    parameter int DV_W = 46,
    parameter int Q_W  = 21
) (
    input  logic            i_clk,
    input  logic            i_en,
    input  logic [DV_W-1:0] i_rem,
    input  logic [DV_W-1:0] i_div,
    output logic [Q_W-1:0]  o_quo
);

    // Restoring division, one quotient bit per stage. The dividend's low
    // part below the starting remainder is all zeros, so zeros shift in.
    logic [DV_W-1:0] r_rem [Q_W];
    logic [DV_W-1:0] r_dvs [Q_W];
    logic [Q_W-1:0]  r_q   [Q_W];

    genvar k;
    for (k = 0; k < Q_W; k++) begin : g_step
        logic [DV_W-1:0] src_rem;
        logic [DV_W-1:0] src_dvs;
        logic [Q_W-1:0]  src_q;
        logic [DV_W:0]   trial;
        logic [DV_W:0]   diff;
        logic            ge;
        if (k == 0) begin : g_first
            assign src_rem = i_rem;
            assign src_dvs = i_div;
            assign src_q   = '0;
        end else begin : g_next
            assign src_rem = r_rem[k-1];
            assign src_dvs = r_dvs[k-1];
            assign src_q   = r_q[k-1];
        end
        assign trial = {src_rem, 1'b0};
        assign ge    = trial >= {1'b0, src_dvs};
        assign diff  = trial - {1'b0, src_dvs};
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= ge ? diff[DV_W-1:0] : trial[DV_W-1:0];
                r_dvs[k] <= src_dvs;
                r_q[k]   <= {src_q[Q_W-2:0], ge};
            end
        end
    end

    assign o_quo = r_q[Q_W-1];

endmodule

`default_nettype wire
